// ===== hw/rtl/pcl_pkg.sv =====
package pcl_pkg;

	// Default list capacity.
	localparam int DEPTH_DEF = 32;

	// Field widths fixed by the transaction format.
	localparam int OP_W   = 2;
	localparam int POS_W  = 8;
	localparam int DATA_W = 8;
	localparam int KIND_W = 2;

	// Opcodes.
	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_GET    = 2'd2;
	localparam logic [OP_W-1:0] OP_PRINT  = 2'd3;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_ELEMENT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INVALID = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FULL    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_END     = 2'd3;

	// One result as it travels from the sequencer to the output register.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] value;
		logic              last;
	} res_t;

endpackage

// ===== hw/rtl/pcl_in_if.sv =====
interface pcl_in_if import pcl_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] element;

	modport source (output valid, opcode, position, element, input ready);
	modport sink (input valid, opcode, position, element, output ready);
endinterface

// ===== hw/rtl/pcl_out_if.sv =====
interface pcl_out_if import pcl_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [DATA_W-1:0] element_out;
	logic              last;

	modport source (output valid, result_kind, element_out, last, input ready);
	modport sink (input valid, result_kind, element_out, last, output ready);
endinterface

// ===== hw/rtl/positional_char_list.sv =====
// Channel  Direction  Fields                              Transaction when
// req      sink       opcode, position, element           req.valid && req.ready
// rsp      source     result_kind, element_out, last      rsp.valid && rsp.ready
//
// One memory port pair and a shift sequencer do all the work, one transaction at a time.
// Add and delete shift the elements behind the position one at a time; get reads one element.
// Print streams every stored element and then an end marker, and waits while rsp stalls.
// A result waits in the output register while the next request is taken.
// Reset clears the fill count and control state; stored bytes are not cleared.
module positional_char_list import pcl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pcl_in_if.sink     req,
	pcl_out_if.source  rsp
);

	logic res_valid;
	res_t res;
	logic res_ready;
	logic out_valid_q;
	res_t out_q;

	pcl_core #(
		.DEPTH(DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// Output register: takes a new result whenever it is empty or draining.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_kind = out_q.kind;
	assign rsp.element_out = out_q.value;
	assign rsp.last        = out_q.last;

endmodule

// ===== hw/rtl/pcl_core.sv =====
module pcl_core import pcl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	pcl_in_if.sink   req,
	output logic     res_valid,
	output res_t     res,
	input  logic     res_ready
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_INS, S_INS_WR, S_DEL, S_DEL_WR, S_PRT, S_PRT_EMIT, S_EMIT
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] ele_q;
	logic [KIND_W-1:0] kind_q;
	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] mem [DEPTH];

	logic [POS_W-1:0]  count_w;
	logic [POS_W-1:0]  pos_m1;
	logic [CW-1:0]     idx_m1;
	logic              accept;
	logic              add_bad;
	logic              range_bad;
	logic              is_full;
	logic              ins_done;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [DATA_W-1:0] mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	// Position checks against the current fill.
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign count_w   = POS_W'(count_q);
	assign pos_m1    = req.position - POS_W'(1);
	assign idx_m1    = idx_q - CW'(1);
	assign add_bad   = (req.position == '0) || (req.position > count_w + POS_W'(1));
	assign range_bad = (req.position > count_w);
	assign is_full   = (count_q == CW'(DEPTH));
	assign ins_done  = (POS_W'(idx_q) == pos_q - POS_W'(1));

	// Memory port control: one read and one write address per cycle.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q[AW-1:0];
		mem_wd = rdata_q;
		mem_re = 1'b0;
		mem_ra = idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				mem_re = accept && (req.opcode == OP_GET);
				mem_ra = pos_m1[AW-1:0];
			end
			S_INS: begin
				if (ins_done) begin
					mem_we = 1'b1;
					mem_wd = ele_q;
				end else begin
					mem_re = 1'b1;
					mem_ra = idx_m1[AW-1:0];
				end
			end
			S_INS_WR: mem_we = 1'b1;
			S_DEL: mem_re = (idx_q != count_q);
			S_DEL_WR: begin
				mem_we = 1'b1;
				mem_wa = idx_m1[AW-1:0];
			end
			S_PRT: mem_re = (idx_q != count_q);
			default: ;
		endcase
	end

	// Element storage with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	// Sequencer: shifts elements one at a time, with a read state and a write state each, and streams listings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
			ele_q   <= '0;
			kind_q  <= KIND_ELEMENT;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.opcode)
							OP_ADD: begin
								if (add_bad) begin
									kind_q  <= KIND_INVALID;
									state_q <= S_EMIT;
								end else if (is_full) begin
									kind_q  <= KIND_FULL;
									state_q <= S_EMIT;
								end else begin
									idx_q   <= count_q;
									pos_q   <= req.position;
									ele_q   <= req.element;
									state_q <= S_INS;
								end
							end
							OP_DELETE: begin
								if (range_bad) begin
									kind_q  <= KIND_INVALID;
									state_q <= S_EMIT;
								end else if (req.position != '0) begin
									idx_q   <= CW'(req.position);
									state_q <= S_DEL;
								end
							end
							OP_GET: begin
								if (range_bad) begin
									kind_q  <= KIND_INVALID;
									state_q <= S_EMIT;
								end else if (req.position != '0) begin
									kind_q  <= KIND_ELEMENT;
									state_q <= S_EMIT;
								end
							end
							OP_PRINT: begin
								idx_q   <= '0;
								state_q <= S_PRT;
							end
							default: ;
						endcase
					end
				end
				S_INS: begin
					if (ins_done) begin
						count_q <= count_q + CW'(1);
						state_q <= S_IDLE;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					idx_q   <= idx_m1;
					state_q <= S_INS;
				end
				S_DEL: begin
					if (idx_q == count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DEL_WR;
					end
				end
				S_DEL_WR: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= S_DEL;
				end
				S_PRT: begin
					if (idx_q == count_q) begin
						kind_q  <= KIND_END;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_PRT_EMIT;
					end
				end
				S_PRT_EMIT: begin
					if (res_ready) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_PRT;
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result offered to the output register.
	always_comb begin
		res_valid = (state_q == S_PRT_EMIT) || (state_q == S_EMIT);
		res.kind  = (state_q == S_PRT_EMIT) ? KIND_ELEMENT : kind_q;
		res.value = (res.kind == KIND_ELEMENT) ? rdata_q : '0;
		res.last  = (state_q == S_EMIT);
	end

	// The fill never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above capacity");

	// An add at position zero leaves the list as it was.
	a_add_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.opcode == OP_ADD) && (req.position == '0) |=>
		count_q == $past(count_q))
		else $error("add at position zero changed the list");

	// The end-of-listing marker always closes its transaction.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KIND_END) |-> res.last)
		else $error("end marker without last");

	// A listing element is never the last result.
	a_prt_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRT_EMIT) |-> !res.last && (res.kind == KIND_ELEMENT))
		else $error("listing element marked last");

endmodule

// ===== sim/positional_char_list_tb.sv =====
`timescale 1ns / 1ps

module positional_char_list_tb;
	import pcl_pkg::*;

	localparam int LIST_DEPTH     = DEPTH_DEF;
	localparam int DIR_ROWS       = 26;
	localparam int RAND_ITEMS     = 200;
	localparam int CALM_ITEMS     = 40;
	localparam int HOLD_AT        = 60;
	localparam int HOLD_CYCLES    = 120;
	// The longest shift produces no result; the drain wait below covers it.
	localparam int DRAIN_CYCLES   = 2 * LIST_DEPTH + 16;
	// The longest quiet gap is one full shift, a random stall and the long hold-off.
	// The limit below is several times that.
	localparam int WATCHDOG_LIMIT = 2000;

	// One row of the directed stimulus table.
	typedef struct {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] elem;
		int                reps;
		bit                typed;
		int                n_typed;
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] value;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pcl_in_if  req_ch ();
	pcl_out_if rsp_ch ();

	positional_char_list #(
		.DEPTH(LIST_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the list and the results still owed by the block.
	logic [DATA_W-1:0] shadow_list[$];
	res_t              fresh_results[$];
	res_t              pending_results[$];
	dir_row_t          dir_rows [DIR_ROWS];

	int unsigned mismatches   = 0;
	int unsigned items_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned full_hits    = 0;
	int unsigned invalid_hits = 0;
	int unsigned print_count  = 0;
	int unsigned max_fill     = 0;
	bit          calm         = 1'b0;
	bit          hold_request = 1'b0;
	bit          hold_done    = 1'b0;

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one transaction to the shadow list and collect the results it causes.
	task automatic list_predict(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] elem);
		int p;
		int fill;
		p = int'(pos);
		fill = shadow_list.size();
		fresh_results.delete();
		case (op)
			OP_ADD: begin
				// The position is checked before the fill level.
				if (p == 0 || p > fill + 1) begin
					fresh_results.push_back('{KIND_INVALID, 8'h00, 1'b0});
				end else if (fill >= LIST_DEPTH) begin
					fresh_results.push_back('{KIND_FULL, 8'h00, 1'b0});
				end else begin
					shadow_list.insert(p - 1, elem);
				end
			end
			OP_DELETE: begin
				if (p > fill) begin
					fresh_results.push_back('{KIND_INVALID, 8'h00, 1'b0});
				end else if (p > 0) begin
					shadow_list.delete(p - 1);
				end
			end
			OP_GET: begin
				if (p > fill) begin
					fresh_results.push_back('{KIND_INVALID, 8'h00, 1'b0});
				end else if (p > 0) begin
					fresh_results.push_back('{KIND_ELEMENT, shadow_list[p - 1], 1'b0});
				end
			end
			default: begin
				foreach (shadow_list[i]) begin
					fresh_results.push_back('{KIND_ELEMENT, shadow_list[i], 1'b0});
				end
				fresh_results.push_back('{KIND_END, 8'h00, 1'b0});
				print_count++;
			end
		endcase
		foreach (fresh_results[i]) begin
			if (fresh_results[i].kind == KIND_FULL) full_hits++;
			if (fresh_results[i].kind == KIND_INVALID) invalid_hits++;
		end
		if (fresh_results.size() > 0) begin
			fresh_results[fresh_results.size() - 1].last = 1'b1;
		end
		if (shadow_list.size() > max_fill) max_fill = shadow_list.size();
	endtask

	// Offer one request transaction, wait for it to be taken, then record what it owes.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] elem, input bit typed, input int n_typed,
			input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value);
		res_t typed_res;
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.opcode   <= op;
		req_ch.position <= pos;
		req_ch.element  <= elem;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		list_predict(op, pos, elem);
		if (typed) begin
			if (n_typed > 0) begin
				typed_res.kind  = kind;
				typed_res.value = value;
				typed_res.last  = 1'b1;
				pending_results.push_back(typed_res);
			end
		end else begin
			foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
		end
		items_sent++;
	endtask

	// Pick a position that is mostly inside 1..top, now and then at or past the edges.
	function automatic logic [POS_W-1:0] pick_pos(input int top);
		int r;
		r = $urandom_range(0, 19);
		if (top == 0 || r == 0) return POS_W'($urandom_range(0, top + 2));
		if (r == 1) return POS_W'(top);
		if (r == 2) return POS_W'(1);
		return POS_W'($urandom_range(1, top));
	endfunction

	// Request side: reset, directed table, random traffic, then drain and report.
	initial begin : stimulus
		int fill;
		int r;
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] elem;
		bit grow;

		req_ch.valid    = 1'b0;
		req_ch.opcode   = OP_ADD;
		req_ch.position = '0;
		req_ch.element  = '0;

		// Directed rows: op, position, element, repeat, typed, count, kind, value.
		dir_rows = '{
			'{OP_PRINT,  8'd0,   8'h00, 1,  1'b1, 1, KIND_END,     8'h00},
			'{OP_GET,    8'd0,   8'h00, 1,  1'b1, 0, KIND_ELEMENT, 8'h00},
			'{OP_DELETE, 8'd0,   8'h00, 1,  1'b1, 0, KIND_ELEMENT, 8'h00},
			'{OP_GET,    8'd1,   8'h00, 1,  1'b1, 1, KIND_INVALID, 8'h00},
			'{OP_DELETE, 8'd1,   8'h00, 1,  1'b1, 1, KIND_INVALID, 8'h00},
			'{OP_ADD,    8'd0,   8'h55, 1,  1'b1, 1, KIND_INVALID, 8'h00},
			'{OP_ADD,    8'd2,   8'h55, 1,  1'b1, 1, KIND_INVALID, 8'h00},
			'{OP_ADD,    8'd1,   8'hFF, 1,  1'b1, 0, KIND_ELEMENT, 8'h00},
			'{OP_ADD,    8'd1,   8'h00, 1,  1'b1, 0, KIND_ELEMENT, 8'h00},
			'{OP_ADD,    8'd3,   8'hA5, 1,  1'b1, 0, KIND_ELEMENT, 8'h00},
			'{OP_GET,    8'd255, 8'h00, 1,  1'b1, 1, KIND_INVALID, 8'h00},
			'{OP_ADD,    8'd255, 8'h12, 1,  1'b1, 1, KIND_INVALID, 8'h00},
			'{OP_GET,    8'd2,   8'h00, 1,  1'b0, 0, KIND_ELEMENT, 8'h00},
			'{OP_PRINT,  8'd255, 8'hFF, 1,  1'b0, 0, KIND_ELEMENT, 8'h00},
			'{OP_DELETE, 8'd2,   8'h00, 1,  1'b0, 0, KIND_ELEMENT, 8'h00},
			'{OP_DELETE, 8'd3,   8'h00, 1,  1'b1, 1, KIND_INVALID, 8'h00},
			'{OP_ADD,    8'd2,   8'h10, 30, 1'b1, 0, KIND_ELEMENT, 8'h00},
			'{OP_ADD,    8'd33,  8'h77, 1,  1'b1, 1, KIND_FULL,    8'h00},
			'{OP_ADD,    8'd1,   8'h77, 1,  1'b1, 1, KIND_FULL,    8'h00},
			'{OP_ADD,    8'd34,  8'h00, 1,  1'b1, 1, KIND_INVALID, 8'h00},
			'{OP_PRINT,  8'd0,   8'h00, 1,  1'b0, 0, KIND_ELEMENT, 8'h00},
			'{OP_GET,    8'd32,  8'h00, 1,  1'b0, 0, KIND_ELEMENT, 8'h00},
			'{OP_GET,    8'd33,  8'h00, 1,  1'b1, 1, KIND_INVALID, 8'h00},
			'{OP_DELETE, 8'd32,  8'h00, 1,  1'b0, 0, KIND_ELEMENT, 8'h00},
			'{OP_DELETE, 8'd1,   8'h00, 31, 1'b0, 0, KIND_ELEMENT, 8'h00},
			'{OP_PRINT,  8'd0,   8'h00, 1,  1'b1, 1, KIND_END,     8'h00}
		};

		// Hold reset at the start, then release it once.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty list, edges of the position range, fill to full, drain.
		foreach (dir_rows[i]) begin
			for (int k = 0; k < dir_rows[i].reps; k++) begin
				send_item(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].elem + DATA_W'(k),
					dir_rows[i].typed, dir_rows[i].n_typed, dir_rows[i].kind,
					dir_rows[i].value);
			end
		end

		// Random part: mostly in-range edits that swing the list between empty and full.
		grow = 1'b1;
		for (int k = 0; k < RAND_ITEMS; k++) begin
			calm = (k >= RAND_ITEMS - CALM_ITEMS);
			if (k == HOLD_AT) hold_request = 1'b1;
			fill = shadow_list.size();
			if (fill == LIST_DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
			if (fill == 0) grow = 1'b1;
			if ($urandom_range(0, 39) == 0) grow = !grow;
			elem = DATA_W'($urandom);
			r = $urandom_range(0, 99);
			if (r < 8) begin
				op  = OP_W'($urandom);
				pos = POS_W'($urandom);
			end else if (r < 15) begin
				op  = OP_PRINT;
				pos = POS_W'($urandom);
			end else if (r < 32) begin
				op  = OP_GET;
				pos = pick_pos(fill);
			end else begin
				op  = (($urandom_range(0, 3) != 0) == grow) ? OP_ADD : OP_DELETE;
				pos = pick_pos(op == OP_ADD ? fill + 1 : fill);
			end
			send_item(op, pos, elem, 1'b0, 0, KIND_ELEMENT, 8'h00);
		end
		req_ch.valid <= 1'b0;

		// Wait for every owed result, then watch for stray ones.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d request transactions (%0d prints), checked %0d results,",
			items_sent, print_count, results_seen);
		$display("%0d list-full and %0d invalid-position; peak fill %0d of %0d, hold-off done: %0b.",
			full_hits, invalid_hits, max_fill, LIST_DEPTH, hold_done);
		if (mismatches == 0) begin
			$display("positional_char_list regression: pass");
		end else begin
			$display("positional_char_list regression: fail");
		end
		$finish;
	end

	// Response side: random stall bursts, one long hold-off, steady ready near the end.
	initial begin : response_sink
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				hold_done    = 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Compare each response transaction with the oldest owed result.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: result_kind %0d element_out %0h last %0b",
					rsp_ch.result_kind, rsp_ch.element_out, rsp_ch.last);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (rsp_ch.result_kind !== want.kind) begin
					$error("result_kind: expected %0d, actual %0d", want.kind,
						rsp_ch.result_kind);
					mismatches++;
				end
				if (rsp_ch.element_out !== want.value) begin
					$error("element_out: expected %0h, actual %0h", want.value,
						rsp_ch.element_out);
					mismatches++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, rsp_ch.last);
					mismatches++;
				end
			end
		end
	end

	// End the run if no transaction happens on either channel for too long.
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("Watchdog expired after %0d cycles without a transaction.", WATCHDOG_LIMIT);
		$display("positional_char_list regression: fail");
		$finish;
	end

endmodule
